// ===== rtl/stack_machine_alu_defines.svh =====
// ----------------------------------------------------------------------------
// Stack machine ALU assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_ALU_DEFINES_SVH
`define STACK_MACHINE_ALU_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SMA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sma_pkg.sv =====
// ----------------------------------------------------------------------------
// Stack machine ALU package
// Stack sizing, instruction kinds and status codes shared by the block.
// ----------------------------------------------------------------------------
package sma_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    localparam logic [2:0] KIND_PUSH  = 3'd0;
    localparam logic [2:0] KIND_SUB   = 3'd1;
    localparam logic [2:0] KIND_DIV   = 3'd2;
    localparam logic [2:0] KIND_MUL   = 3'd3;
    localparam logic [2:0] KIND_MOD   = 3'd4;
    localparam logic [2:0] KIND_PCHAR = 3'd5;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_SHORT   = 3'd1;
    localparam logic [2:0] ST_DIVZERO = 3'd2;
    localparam logic [2:0] ST_CHAR    = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    localparam logic [31:0] CHAR_MAX = 32'd127;

endpackage

// ===== rtl/sma_in_if.sv =====
// ----------------------------------------------------------------------------
// Stack machine ALU instruction channel
// Carries one instruction word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sma_in_if;

    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic signed [31:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);

endinterface

// ===== rtl/sma_out_if.sv =====
// ----------------------------------------------------------------------------
// Stack machine ALU result channel
// Carries one result word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sma_out_if;

    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [31:0] top_value;
    logic [6:0]         char_code;
    logic               char_valid;

    modport source (output valid, output status, output top_value, output char_code,
                    output char_valid, input ready);
    modport sink   (input valid, input status, input top_value, input char_code,
                    input char_valid, output ready);

endinterface

// ===== rtl/stack_machine_alu.sv =====
// ----------------------------------------------------------------------------
// Stack machine ALU
// Executes push, sub, div, mul, mod and pchar on a bounded word stack.
// ----------------------------------------------------------------------------
// Each instruction word produces exactly one result word, and one instruction
// is in flight at a time. Push, pchar, unused kinds and instructions rejected
// for a short stack go straight to the result. Sub and mul read the second
// operand from the stack memory through its registered read port and write
// the result back in a state of its own. A zero divisor is caught once the
// operands are read. Div and mod use the shared restoring divider, which
// resolves one quotient bit per cycle, followed by a sign fixup and the write
// back. The result word reaches the output register in the same cycle as the
// block returns to idle and is ready again, and a result that is still
// waiting in that register holds the block until it is taken.
module stack_machine_alu
    import sma_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    sma_in_if.sink    cmd,
    sma_out_if.source rsp
);

`include "stack_machine_alu_defines.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIVIDE,
        S_FIXUP,
        S_WRITE,
        S_RESULT
    } state_t;

    localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(STACK_DEPTH);

    state_t               state_reg, state_next;
    logic [2:0]           kind_reg, kind_next;
    logic [DEPTH_W-1:0]   depth_reg, depth_next;
    logic [31:0]          top_reg, top_next;
    logic [31:0]          res_reg, res_next;
    logic [31:0]          rem_reg, rem_next;
    logic [31:0]          quo_reg, quo_next;
    logic [31:0]          dvs_reg, dvs_next;
    logic [4:0]           cnt_reg, cnt_next;
    logic                 neg_reg, neg_next;
    logic [2:0]           status_reg, status_next;
    logic [6:0]           char_code_reg, char_code_next;
    logic                 char_valid_reg, char_valid_next;
    logic                 out_valid_reg, out_valid_next;
    logic [2:0]           out_status_reg, out_status_next;
    logic [31:0]          out_top_reg, out_top_next;
    logic [6:0]           out_char_code_reg, out_char_code_next;
    logic                 out_char_valid_reg, out_char_valid_next;

    logic [31:0]          stack_mem [STACK_DEPTH];
    logic [31:0]          rd_data_reg;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [31:0]          mem_wdata;
    logic [DEPTH_W-1:0]   depth_minus2;
    logic [31:0]          op_a, op_b, product, mag_a, mag_b, mag_res;
    logic [32:0]          trial;
    logic                 cmd_fire;
    logic                 push_room;
    logic                 char_out;
    logic [DEPTH_W-1:0]   depth_plus1;

    assign depth_minus2 = depth_reg - DEPTH_W'(2);
    assign op_a         = rd_data_reg;
    assign op_b         = top_reg;
    assign product      = op_a * op_b;
    assign mag_a        = op_a[31] ? (~op_a + 32'd1) : op_a;
    assign mag_b        = op_b[31] ? (~op_b + 32'd1) : op_b;
    assign trial        = {rem_reg, quo_reg[31]} - {1'b0, dvs_reg};
    assign mag_res      = (kind_reg == KIND_DIV) ? quo_reg : rem_reg;

    assign cmd_fire    = cmd.valid && cmd.ready;
    assign push_room   = cmd_fire && (cmd.kind == KIND_PUSH) && (depth_reg != DEPTH_FULL);
    assign char_out    = out_valid_reg && out_char_valid_reg;
    assign depth_plus1 = depth_reg + DEPTH_W'(1);

    assign cmd.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.top_value  = out_top_reg;
    assign rsp.char_code  = out_char_code_reg;
    assign rsp.char_valid = out_char_valid_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= stack_mem[depth_minus2[ADDR_W-1:0]];
    end

    always_comb
    begin
        state_next          = state_reg;
        kind_next           = kind_reg;
        depth_next          = depth_reg;
        top_next            = top_reg;
        res_next            = res_reg;
        rem_next            = rem_reg;
        quo_next            = quo_reg;
        dvs_next            = dvs_reg;
        cnt_next            = cnt_reg;
        neg_next            = neg_reg;
        status_next         = status_reg;
        char_code_next      = char_code_reg;
        char_valid_next     = char_valid_reg;
        out_valid_next      = out_valid_reg && !rsp.ready;
        out_status_next     = out_status_reg;
        out_top_next        = out_top_reg;
        out_char_code_next  = out_char_code_reg;
        out_char_valid_next = out_char_valid_reg;
        mem_we              = 1'b0;
        mem_waddr           = depth_minus2[ADDR_W-1:0];
        mem_wdata           = res_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    kind_next       = cmd.kind;
                    status_next     = ST_OK;
                    char_code_next  = 7'd0;
                    char_valid_next = 1'b0;
                    state_next      = S_RESULT;
                    case (cmd.kind)
                        KIND_PUSH:
                        begin
                            if (depth_reg == DEPTH_FULL)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = depth_reg[ADDR_W-1:0];
                                mem_wdata  = cmd.value;
                                top_next   = cmd.value;
                                depth_next = depth_reg + DEPTH_W'(1);
                            end
                        end
                        KIND_SUB, KIND_DIV, KIND_MUL, KIND_MOD:
                        begin
                            if (depth_reg < DEPTH_W'(2))
                            begin
                                status_next = ST_SHORT;
                            end
                            else
                            begin
                                state_next = S_EXEC;
                            end
                        end
                        KIND_PCHAR:
                        begin
                            if (depth_reg == DEPTH_W'(0))
                            begin
                                status_next = ST_SHORT;
                            end
                            else if (top_reg > CHAR_MAX)
                            begin
                                status_next = ST_CHAR;
                            end
                            else
                            begin
                                char_code_next  = top_reg[6:0];
                                char_valid_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_EXEC:
            begin
                case (kind_reg)
                    KIND_SUB:
                    begin
                        res_next   = op_a - op_b;
                        state_next = S_WRITE;
                    end
                    KIND_MUL:
                    begin
                        res_next   = product;
                        state_next = S_WRITE;
                    end
                    KIND_DIV, KIND_MOD:
                    begin
                        if (op_b == 32'd0)
                        begin
                            status_next = ST_DIVZERO;
                            state_next  = S_RESULT;
                        end
                        else
                        begin
                            rem_next   = 32'd0;
                            quo_next   = mag_a;
                            dvs_next   = mag_b;
                            cnt_next   = 5'd0;
                            neg_next   = (kind_reg == KIND_DIV) ? (op_a[31] ^ op_b[31])
                                                                : op_a[31];
                            state_next = S_DIVIDE;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESULT;
                    end
                endcase
            end
            S_DIVIDE:
            begin
                if (!trial[32])
                begin
                    rem_next = trial[31:0];
                end
                else
                begin
                    rem_next = {rem_reg[30:0], quo_reg[31]};
                end
                quo_next = {quo_reg[30:0], ~trial[32]};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    state_next = S_FIXUP;
                end
            end
            S_FIXUP:
            begin
                res_next   = neg_reg ? (~mag_res + 32'd1) : mag_res;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                mem_we     = 1'b1;
                top_next   = res_reg;
                depth_next = depth_reg - DEPTH_W'(1);
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next      = 1'b1;
                    out_status_next     = status_reg;
                    out_top_next        = (depth_reg == DEPTH_W'(0)) ? 32'd0 : top_reg;
                    out_char_code_next  = char_code_reg;
                    out_char_valid_next = char_valid_reg;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            kind_reg           <= KIND_PUSH;
            depth_reg          <= '0;
            top_reg            <= '0;
            res_reg            <= '0;
            rem_reg            <= '0;
            quo_reg            <= '0;
            dvs_reg            <= '0;
            cnt_reg            <= '0;
            neg_reg            <= 1'b0;
            status_reg         <= ST_OK;
            char_code_reg      <= '0;
            char_valid_reg     <= 1'b0;
            out_valid_reg      <= 1'b0;
            out_status_reg     <= ST_OK;
            out_top_reg        <= '0;
            out_char_code_reg  <= '0;
            out_char_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            kind_reg           <= kind_next;
            depth_reg          <= depth_next;
            top_reg            <= top_next;
            res_reg            <= res_next;
            rem_reg            <= rem_next;
            quo_reg            <= quo_next;
            dvs_reg            <= dvs_next;
            cnt_reg            <= cnt_next;
            neg_reg            <= neg_next;
            status_reg         <= status_next;
            char_code_reg      <= char_code_next;
            char_valid_reg     <= char_valid_next;
            out_valid_reg      <= out_valid_next;
            out_status_reg     <= out_status_next;
            out_top_reg        <= out_top_next;
            out_char_code_reg  <= out_char_code_next;
            out_char_valid_reg <= out_char_valid_next;
        end
    end

    // The stack never holds more entries than the memory has rows.
    `SMA_ASSERT_SAME(a_depth_bound, 1'b1, depth_reg <= DEPTH_FULL, "stack depth out of range")
    // A character is only reported together with a successful status.
    `SMA_ASSERT_SAME(a_char_ok, char_out, out_status_reg == ST_OK, "char with error status")
    // An accepted push onto a stack with room grows the stack by one entry.
    `SMA_ASSERT_NEXT(a_push_grow, push_room, depth_reg == $past(depth_plus1), "push did not grow")
    // Nothing is accepted while an instruction is still in flight.
    `SMA_ASSERT_NEXT(a_one_in_flight, cmd_fire, !cmd.ready, "second word accepted in flight")

endmodule
